/* rtl/bffl_pkg.sv */
// bffl_pkg: shared types and constants of the best-fit free list allocator.
// Holds the transaction payload structs, the hole entry type and the codes.
// No dependencies.
`timescale 1ns / 1ps

package bffl_pkg;

  localparam logic        KIND_ALLOC = 1'b0;
  localparam logic        KIND_FREE  = 1'b1;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_DROPPED   = 2'd1;
  localparam logic [1:0]  ST_SATURATED = 2'd2;

  localparam logic [31:0] START_OFFSET_RST = 32'd25;
  localparam logic [31:0] MAX32            = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] record_size;
    logic [31:0] record_offset;
  } in_item_t;

  typedef struct packed {
    logic [31:0] placed_offset;
    logic [15:0] granted_size;
    logic [15:0] pad_bytes;
    logic        reused_hole;
    logic [1:0]  status;
    logic [31:0] live_count;
    logic [31:0] hole_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] size;
  } hole_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

/* rtl/bffl_hole_ram.sv */
// bffl_hole_ram: hole store, one write port and one registered read port.
// Depends on bffl_pkg for the hole entry type.
`timescale 1ns / 1ps

module bffl_hole_ram #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bffl_pkg::hole_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output bffl_pkg::hole_t          rd_data
);
  import bffl_pkg::*;

  hole_t mem_r [DEPTH];
  hole_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/best_fit_free_list_allocator_top.sv */
// best_fit_free_list_allocator_top: best-fit allocator over a size-sorted free list.
// Depends on bffl_pkg and bffl_hole_ram.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    bffl_pkg::in_item_t  (kind, size, offset)
// out_     output     out_valid / out_ready  bffl_pkg::out_item_t (placement, counts)
// cfg_     input      cfg_valid / cfg_ready  start offset, 32 bits
//
// A transaction walks the hole store over at most the holes in use, one entry
// a cycle through its single read port and one size comparator. A full-list
// free and any request on an empty list skip the walk and go straight to the
// final step. Reset (rst_n, synchronous, low) empties the list and loads the
// end offset with 25; the store needs no clearing. A stalled result sits in the
// output register; a new transaction is taken meanwhile, and its walk holds at
// the final step until the register is free.

module best_fit_free_list_allocator_top #(
  parameter int FREE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bffl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bffl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import bffl_pkg::*;

  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);

  // sequencer and request
  state_t         state_r, state_nxt;
  in_item_t       req_r, req_nxt;

  // allocator state
  logic [CW-1:0]  used_r, used_nxt;
  logic [31:0]    end_r, end_nxt;
  logic [31:0]    live_r, live_nxt;
  logic [31:0]    removed_r, removed_nxt;

  // walk control
  logic [AW-1:0]  iss_r, iss_nxt;
  logic           iss_more_r, iss_more_nxt;
  logic           pend_r, pend_nxt;
  logic [AW-1:0]  pidx_r, pidx_nxt;
  logic           found_r, found_nxt;
  hole_t          hit_r, hit_nxt;
  logic           fin_wr_r, fin_wr_nxt;
  logic [AW-1:0]  fin_addr_r, fin_addr_nxt;

  // result register
  out_item_t      out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // store ports
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  hole_t          wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  hole_t          rd_data;

  logic [AW-1:0]  used_m1;
  logic           stop;
  logic           fin_go;
  logic [32:0]    end_sum;

  bffl_hole_ram #(
    .DEPTH (FREE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign used_m1 = AW'(used_r - CW'(1));
  assign fin_go  = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign end_sum = {1'b0, end_r} + {17'd0, req_r.record_size};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    used_nxt      = used_r;
    end_nxt       = end_r;
    live_nxt      = live_r;
    removed_nxt   = removed_r;
    iss_nxt       = iss_r;
    iss_more_nxt  = iss_more_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    fin_wr_nxt    = fin_wr_r;
    fin_addr_nxt  = fin_addr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = iss_r;
    stop          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          found_nxt    = 1'b0;
          fin_addr_nxt = '0;
          fin_wr_nxt   = (in_data.kind == KIND_FREE) && (used_r < CW'(FREE_DEPTH));
          iss_more_nxt = 1'b1;
          // free walks down from the top entry, allocate walks up from the first
          iss_nxt      = (in_data.kind == KIND_FREE) ? used_m1 : '0;
          if ((used_r == '0) || (in_data.kind == KIND_FREE && used_r >= CW'(FREE_DEPTH))) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (pend_r) begin
          if (req_r.kind == KIND_FREE) begin
            if (rd_data.size > req_r.record_size) begin
              // shift the larger hole up by one
              wr_en   = 1'b1;
              wr_addr = AW'(pidx_r + AW'(1));
              if (pidx_r == '0) begin
                stop         = 1'b1;
                fin_addr_nxt = '0;
              end
            end else begin
              stop         = 1'b1;
              fin_addr_nxt = AW'(pidx_r + AW'(1));
            end
          end else begin
            if (found_r) begin
              // close the gap left by the taken hole
              wr_en   = 1'b1;
              wr_addr = AW'(pidx_r - AW'(1));
            end else if (rd_data.size >= req_r.record_size) begin
              found_nxt = 1'b1;
              hit_nxt   = rd_data;
            end
            if (pidx_r == used_m1) begin
              stop = 1'b1;
            end
          end
        end

        if (stop) begin
          state_nxt    = S_FINISH;
          iss_more_nxt = 1'b0;
        end else if (iss_more_r) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = iss_r;
          if (req_r.kind == KIND_FREE) begin
            iss_more_nxt = (iss_r != '0);
            iss_nxt      = AW'(iss_r - AW'(1));
          end else begin
            iss_more_nxt = (iss_r != used_m1);
            iss_nxt      = AW'(iss_r + AW'(1));
          end
        end
      end

      S_FINISH: begin
        if (fin_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (req_r.kind == KIND_FREE) begin
            live_nxt = (live_r == '0) ? live_r : live_r - 32'd1;
            if (fin_wr_r) begin
              wr_en       = 1'b1;
              wr_addr     = fin_addr_r;
              wr_data     = '{offset: req_r.record_offset, size: req_r.record_size};
              used_nxt    = CW'(used_r + CW'(1));
              removed_nxt = (removed_r == MAX32) ? removed_r : removed_r + 32'd1;
            end else begin
              out_nxt.status = ST_DROPPED;
            end
          end else begin
            live_nxt = (live_r == MAX32) ? live_r : live_r + 32'd1;
            if (found_r) begin
              out_nxt.placed_offset = hit_r.offset;
              out_nxt.granted_size  = hit_r.size;
              out_nxt.pad_bytes     = hit_r.size - req_r.record_size;
              out_nxt.reused_hole   = 1'b1;
              used_nxt              = CW'(used_r - CW'(1));
              removed_nxt           = (removed_r == '0) ? removed_r : removed_r - 32'd1;
            end else begin
              out_nxt.placed_offset = end_r;
              out_nxt.granted_size  = req_r.record_size;
              if (end_sum[32]) begin
                end_nxt        = MAX32;
                out_nxt.status = ST_SATURATED;
              end else begin
                end_nxt = end_sum[31:0];
              end
            end
          end
          out_nxt.live_count = live_nxt;
          out_nxt.hole_count = removed_nxt;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration must arrive only while idle; the block does not enforce it; load the end offset at once
    if (cfg_valid) begin
      end_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      end_r       <= START_OFFSET_RST;
      live_r      <= '0;
      removed_r   <= '0;
      pend_r      <= 1'b0;
      iss_more_r  <= 1'b0;
      found_r     <= 1'b0;
      fin_wr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      end_r       <= end_nxt;
      live_r      <= live_nxt;
      removed_r   <= removed_nxt;
      pend_r      <= pend_nxt;
      iss_more_r  <= iss_more_nxt;
      found_r     <= found_nxt;
      fin_wr_r    <= fin_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    iss_r      <= iss_nxt;
    pidx_r     <= pidx_nxt;
    hit_r      <= hit_nxt;
    fin_addr_r <= fin_addr_nxt;
    out_r      <= out_nxt;
  end

endmodule

/* rtl/bffl_checker.sv */
// bffl_checker: port-level assertions for the best-fit allocator top level.
// Depends on bffl_pkg; bound to best_fit_free_list_allocator_top below.
`timescale 1ns / 1ps

module bffl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bffl_pkg::out_item_t out_data
);
  import bffl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the sequencer is busy in the cycle after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // a reused hole always covers the request and never saturates the end offset
  a_reuse_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reused_hole |->
      out_data.pad_bytes <= out_data.granted_size && out_data.status == ST_OK)
    else $error("inconsistent reuse result");

  // a dropped free never carries a placement
  a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_DROPPED |->
      out_data.placed_offset == '0 && out_data.granted_size == '0 && !out_data.reused_hole)
    else $error("dropped free carries placement");

endmodule

bind best_fit_free_list_allocator_top bffl_checker u_bffl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/tb.sv */
// tb: self-checking bench for best_fit_free_list_allocator_top.
// Holds a placement tracker class that predicts each result, and tasks that drive the block.
// Depends on bffl_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb;
  import bffl_pkg::*;

  localparam int FREE_DEPTH = 64;
  localparam int IDLE_PCT   = 37;
  localparam int PHASE_ITEMS = 380;

  // Tracks the free list, the end offset and both record counts, predicts the
  // result of every accepted request and compares it with what the block returns.
  class placement_tracker;
    logic [31:0]  hole_off [FREE_DEPTH];
    logic [15:0]  hole_sz  [FREE_DEPTH];
    int unsigned  holes_used;
    logic [31:0]  end_off;
    logic [31:0]  live;
    logic [31:0]  removed;
    out_item_t    expected_placements[$];
    int unsigned  mismatches;

    function new();
      holes_used  = 0;
      end_off     = START_OFFSET_RST;
      live        = '0;
      removed     = '0;
      mismatches  = 0;
    endfunction

    function void set_start(logic [31:0] value);
      end_off   = value;
    endfunction

    function out_item_t note_request(in_item_t rq);
      out_item_t   r;
      int          pos;
      logic [32:0] sum;
      r = '0;
      if (rq.kind == KIND_FREE) begin
        if (live != '0) live--;
        if (holes_used >= FREE_DEPTH) begin
          r.status = ST_DROPPED;
        end else begin
          pos = int'(holes_used);
          for (int i = 0; i < int'(holes_used); i++) begin
            if (hole_sz[i] > rq.record_size) begin
              pos = i;
              break;
            end
          end
          for (int i = int'(holes_used); i > pos; i--) begin
            hole_off[i] = hole_off[i-1];
            hole_sz[i]  = hole_sz[i-1];
          end
          hole_off[pos] = rq.record_offset;
          hole_sz[pos]  = rq.record_size;
          holes_used++;
          if (removed != MAX32) removed++;
        end
      end else begin
        pos = int'(holes_used);
        for (int i = 0; i < int'(holes_used); i++) begin
          if (hole_sz[i] >= rq.record_size) begin
            pos = i;
            break;
          end
        end
        if (pos < int'(holes_used)) begin
          r.placed_offset = hole_off[pos];
          r.granted_size  = hole_sz[pos];
          r.pad_bytes     = hole_sz[pos] - rq.record_size;
          r.reused_hole   = 1'b1;
          for (int i = pos; i + 1 < int'(holes_used); i++) begin
            hole_off[i] = hole_off[i+1];
            hole_sz[i]  = hole_sz[i+1];
          end
          holes_used--;
          if (removed != '0) removed--;
        end else begin
          r.placed_offset = end_off;
          r.granted_size  = rq.record_size;
          sum = {1'b0, end_off} + {17'd0, rq.record_size};
          if (sum[32]) begin
            end_off  = MAX32;
            r.status = ST_SATURATED;
          end else begin
            end_off = sum[31:0];
          end
        end
        if (live != MAX32) live++;
      end
      r.live_count = live;
      r.hole_count = removed;
      expected_placements.push_back(r);
      return r;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_placement(out_item_t got);
      out_item_t want;
      if (expected_placements.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        mismatches++;
        return;
      end
      want = expected_placements.pop_front();
      compare_field("placed_offset", want.placed_offset, got.placed_offset);
      compare_field("granted_size", 32'(want.granted_size), 32'(got.granted_size));
      compare_field("pad_bytes", 32'(want.pad_bytes), 32'(got.pad_bytes));
      compare_field("reused_hole", 32'(want.reused_hole), 32'(got.reused_hole));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("live_count", want.live_count, got.live_count);
      compare_field("hole_count", want.hole_count, got.hole_count);
    endfunction

    function int unsigned outstanding();
      return expected_placements.size();
    endfunction
  endclass

  // Every input carries a known value from time zero.
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  // High during the stretch in which neither side idles.
  logic        calm      = 1'b0;

  placement_tracker tracker = new();

  // Records the bench believes are live, so that most frees return real space.
  hole_t live_pool[$];

  always #2 clk = ~clk;

  best_fit_free_list_allocator_top #(
    .FREE_DEPTH (FREE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Stall the result channel at random, except during the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Check every result transaction as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_placement(out_data);
    end
  end

  // Offer one request, holding valid and payload until the block takes it.
  // Idle cycles go in front of the request; valid drops only in those idle cycles.
  task automatic send_item(in_item_t it);
    out_item_t r;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = tracker.note_request(it);
    if (it.kind == KIND_ALLOC) begin
      live_pool.push_back('{offset: r.placed_offset, size: r.granted_size});
    end
  endtask

  task automatic send_req(logic kind, logic [15:0] size, logic [31:0] offset);
    in_item_t it;
    it.kind          = kind;
    it.record_size   = size;
    it.record_offset = offset;
    send_item(it);
  endtask

  // Drop valid and hold until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Load a new start offset; only called with the block idle.
  task automatic write_start(logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_start(value);
  endtask

  function automatic logic [15:0] alloc_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return 16'($urandom_range(1, 48));
    if (pick < 92) return 16'($urandom_range(49, 4096));
    if (pick < 97) return 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 2))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'd1;
    endcase
  endfunction

  // Build one random request. Most frees hand back a live record whole; the
  // rest are noise with any offset and size.
  function automatic in_item_t random_request(int free_pct);
    in_item_t it;
    hole_t    h;
    int       idx;
    it.record_offset = $urandom();
    if ($urandom_range(0, 99) >= free_pct) begin
      it.kind        = KIND_ALLOC;
      it.record_size = alloc_size();
    end else begin
      it.kind = KIND_FREE;
      if (live_pool.size() != 0 && $urandom_range(0, 99) < 75) begin
        idx = $urandom_range(0, live_pool.size() - 1);
        h   = live_pool[idx];
        live_pool.delete(idx);
        it.record_offset = h.offset;
        it.record_size   = h.size;
      end else if ($urandom_range(0, 1) == 0) begin
        it.record_size = 16'($urandom_range(0, 65535));
      end else begin
        it.record_size = 16'($urandom_range(0, 48));
      end
    end
    return it;
  endfunction

  logic [31:0] phase_start [5];
  int          phase_free  [5];

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset start offset: appends of the extreme sizes,
    // frees past zero live records, a zero-size hole ahead of the rest, equal
    // sizes kept in arrival order, reuse with padding.
    send_req(KIND_ALLOC, 16'd10,    $urandom());
    send_req(KIND_ALLOC, 16'hFFFF,  $urandom());
    send_req(KIND_ALLOC, 16'd0,     $urandom());
    send_req(KIND_FREE,  16'd10,    32'd25);
    send_req(KIND_FREE,  16'hFFFF,  32'hFFFF_FFFF);
    send_req(KIND_FREE,  16'd0,     32'd0);
    send_req(KIND_FREE,  16'd10,    32'd100);
    send_req(KIND_ALLOC, 16'd0,     $urandom());
    send_req(KIND_ALLOC, 16'd5,     $urandom());
    send_req(KIND_ALLOC, 16'd10,    $urandom());
    send_req(KIND_ALLOC, 16'd1,     $urandom());
    send_req(KIND_ALLOC, 16'd1,     $urandom());
    drain();

    // Push the end offset past the top of the space and sit there.
    write_start(32'hFFFF_FFF0);
    send_req(KIND_ALLOC, 16'hFFFF,  32'h0);
    send_req(KIND_ALLOC, 16'd1,     32'hFFFF_FFFF);
    send_req(KIND_ALLOC, 16'd0,     $urandom());
    send_req(KIND_FREE,  16'd1,     32'hFFFF_FFFF);
    send_req(KIND_ALLOC, 16'd2,     $urandom());
    drain();

    // Random phases, each on its own start offset and with a free/allocate mix:
    // the free-heavy one overruns the list, and the allocate-heavy one, the third,
    // drains it and runs with neither side idling.
    phase_start = '{32'd0, 32'hFFFF_FFFF, $urandom(), 32'hFFFF_0000, START_OFFSET_RST};
    phase_free  = '{50, 80, 35, 50, 55};
    for (int p = 0; p < 5; p++) begin
      write_start(phase_start[p]);
      calm <= (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_request(phase_free[p]));
      end
      drain();
      calm <= 1'b0;
    end

    // Allow for a stray result after the last one expected.
    repeat (FREE_DEPTH + 8) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $error("%0d results never arrived", tracker.outstanding());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
